// ===== design/lsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    localparam int PAGE_COUNT_DEF = 1024;
    localparam int SLOT_COUNT_DEF = 8;

    localparam int PAGE_W   = 10;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 4;
    localparam int STAMP_W  = 64;
    localparam int KEY_W    = STAMP_W + 1;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_EVICT  = 1'b1;

    localparam logic REG_ACTIVE_SLOTS = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT     = 3'd0,
        STAT_LOADED  = 3'd1,
        STAT_FAILED  = 3'd2,
        STAT_EVICTED = 3'd3,
        STAT_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SEARCH,
        ST_OWNER,
        ST_COMMIT,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== design/lsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsc_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/lsc_lru_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsc_lru_search #(
    parameter int SLOT_COUNT = 8,
    localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [SLOT_COUNT-1:0]                   cand,
    input  logic [SLOT_COUNT-1:0][lsc_pkg::KEY_W-1:0] key,
    output logic                                    done,
    output logic                                    found,
    output logic                                    best_used,
    output logic [SIW-1:0]                          best_idx
);

    import lsc_pkg::*;

    localparam int LV = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 0;
    localparam int N2 = 1 << LV;
    localparam int CW = (LV > 0) ? $clog2(LV + 1) : 1;

    logic [N2-1:0]             v_reg;
    logic [N2-1:0]             v_next;
    logic [N2-1:0][KEY_W-1:0]  k_reg;
    logic [N2-1:0][KEY_W-1:0]  k_next;
    logic [N2-1:0][SIW-1:0]    i_reg;
    logic [N2-1:0][SIW-1:0]    i_next;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic                      run_reg;
    logic                      run_next;
    logic                      at_end;

    assign at_end = (cnt_reg == CW'(LV));

    // one tree level per cycle, left entry wins on a tie
    always_comb
    begin
        v_next   = v_reg;
        k_next   = k_reg;
        i_next   = i_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start)
        begin
            for (int j = 0; j < N2; j++)
            begin
                if (j < SLOT_COUNT)
                begin
                    v_next[j] = cand[j];
                    k_next[j] = key[j];
                end
                else
                begin
                    v_next[j] = 1'b0;
                    k_next[j] = '0;
                end
                i_next[j] = SIW'(j);
            end
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg && !at_end)
        begin
            for (int j = 0; j < N2 / 2; j++)
            begin
                if (v_reg[2*j+1] && (!v_reg[2*j] || (k_reg[2*j+1] < k_reg[2*j])))
                begin
                    v_next[j] = 1'b1;
                    k_next[j] = k_reg[2*j+1];
                    i_next[j] = i_reg[2*j+1];
                end
                else
                begin
                    v_next[j] = v_reg[2*j];
                    k_next[j] = k_reg[2*j];
                    i_next[j] = i_reg[2*j];
                end
            end
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= v_next;
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        i_reg <= i_next;
    end

    assign done      = run_reg && at_end;
    assign found     = v_reg[0];
    assign best_used = k_reg[0][KEY_W-1];
    assign best_idx  = i_reg[0];

endmodule

`default_nettype wire

// ===== design/lru_slot_page_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | contents
// s_axis    | in        | op transaction: tuser opcode, tdata page_index and load_ok
// m_axis    | out       | result transaction: tuser status, tdata slot and displacement
// apb       | in/out    | register active_slots at byte address 0
//
// one op at a time; hit, out-of-range page and failed load: LOOK, RESP
// evict with nothing to evict: LOOK, SEARCH, RESP
// evict or miss into a free slot: LOOK, SEARCH, then OWNER or COMMIT, RESP
// miss that displaces a page: LOOK, SEARCH, OWNER, COMMIT, RESP
// after reset a clearing pass sweeps every page table entry, s_tready low
// the result register lets the next op enter while m_tready is low

module lru_slot_page_cache #(
    parameter int PAGE_COUNT = lsc_pkg::PAGE_COUNT_DEF,
    parameter int SLOT_COUNT = lsc_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // page_index[9:0], load_ok[10], zero fill
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot[2:0], displaced_valid[3], displaced_page[13:4]
    output logic [2:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import lsc_pkg::*;

    localparam int PAW = $clog2(PAGE_COUNT);
    localparam int PMW = $clog2(SLOT_COUNT + 1);
    localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [ACT_W-1:0] ACT_RST = (SLOT_COUNT > 15) ? 4'd15 : ACT_W'(SLOT_COUNT);

    state_t state_reg;
    state_t state_next;

    logic [ACT_W-1:0]  act_reg;
    logic [ACT_W-1:0]  act_eff;
    logic              accept;
    logic              cfg_wr;

    logic              op_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              ok_reg;
    logic              in_range;

    logic [SLOT_COUNT-1:0]              used_reg;
    logic [SLOT_COUNT-1:0]              used_next;
    logic [SLOT_COUNT-1:0][STAMP_W-1:0] stamp_reg;
    logic [SLOT_COUNT-1:0][STAMP_W-1:0] stamp_next;
    logic [STAMP_W-1:0]                 tick_reg;
    logic [STAMP_W-1:0]                 tick_next;

    logic [PAW-1:0]    clr_reg;
    logic [PAW-1:0]    clr_next;
    logic [SIW-1:0]    pick_reg;
    logic [SIW-1:0]    pick_next;
    logic              dv_reg;
    logic              dv_next;
    logic [PAGE_W-1:0] dp_reg;
    logic [PAGE_W-1:0] dp_next;

    status_t           res_status_reg;
    status_t           res_status_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;
    logic              res_dv_reg;
    logic              res_dv_next;
    logic [PAGE_W-1:0] res_dp_reg;
    logic [PAGE_W-1:0] res_dp_next;

    logic              out_valid_reg;
    logic              out_load;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_dv_reg;
    logic [PAGE_W-1:0] out_dp_reg;

    logic              pm_we;
    logic [PAW-1:0]    pm_waddr;
    logic [PMW-1:0]    pm_wdata;
    logic [PMW-1:0]    pm_q;
    logic [SIW-1:0]    hit_idx;

    logic              ow_we;
    logic              ow_re;
    logic [PAGE_W-1:0] ow_q;

    logic [SLOT_COUNT-1:0]            cand;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] key;
    logic              sr_done;
    logic              sr_found;
    logic              sr_used;
    logic [SIW-1:0]    sr_idx;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SLOTS);
    assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? {28'd0, act_reg} : 32'd0;
    assign act_eff = (act_reg == 4'd0) ? 4'd1 : act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_RST;
        end
        else if (cfg_wr)
        begin
            act_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(page_reg) < 32'(PAGE_COUNT));
    assign hit_idx  = SIW'(pm_q - PMW'(1));

    // search keys: free slots rank first for an access, stamp order after that
    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            if (s_tuser == OP_EVICT)
            begin
                cand[j] = (32'(j) < 32'(act_eff)) && used_reg[j];
                key[j]  = {1'b0, stamp_reg[j]};
            end
            else
            begin
                cand[j] = (32'(j) < 32'(act_eff));
                key[j]  = used_reg[j] ? {1'b1, stamp_reg[j]} : '0;
            end
        end
    end

    lsc_lru_search #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cand     (cand),
        .key      (key),
        .done     (sr_done),
        .found    (sr_found),
        .best_used(sr_used),
        .best_idx (sr_idx)
    );

    lsc_ram #(
        .DEPTH(PAGE_COUNT),
        .WIDTH(PMW)
    ) u_page_map (
        .clk  (clk),
        .we   (pm_we),
        .waddr(pm_waddr),
        .wdata(pm_wdata),
        .re   (accept),
        .raddr(PAW'(s_tdata[PAGE_W-1:0])),
        .rdata(pm_q)
    );

    lsc_ram #(
        .DEPTH(SLOT_COUNT),
        .WIDTH(PAGE_W)
    ) u_owner (
        .clk  (clk),
        .we   (ow_we),
        .waddr(pick_reg),
        .wdata(page_reg),
        .re   (ow_re),
        .raddr(sr_idx),
        .rdata(ow_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PAW'(PAGE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (op_reg == OP_EVICT)
                begin
                    state_next = ST_SEARCH;
                end
                else if (!in_range || (pm_q != '0) || !ok_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sr_done)
                begin
                    if (op_reg == OP_EVICT)
                    begin
                        state_next = sr_found ? ST_OWNER : ST_RESP;
                    end
                    else
                    begin
                        state_next = sr_used ? ST_OWNER : ST_COMMIT;
                    end
                end
            end
            ST_OWNER:
            begin
                state_next = (op_reg == OP_EVICT) ? ST_RESP : ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    // datapath controls
    always_comb
    begin
        pm_we           = 1'b0;
        pm_waddr        = clr_reg;
        pm_wdata        = '0;
        ow_we           = 1'b0;
        ow_re           = 1'b0;
        clr_next        = clr_reg;
        pick_next       = pick_reg;
        dv_next         = dv_reg;
        dp_next         = dp_reg;
        used_next       = used_reg;
        stamp_next      = stamp_reg;
        tick_next       = tick_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_dv_next     = res_dv_reg;
        res_dp_next     = res_dp_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                pm_we    = 1'b1;
                clr_next = clr_reg + PAW'(1);
            end
            ST_LOOK:
            begin
                res_slot_next = '0;
                res_dv_next   = 1'b0;
                res_dp_next   = '0;
                dv_next       = 1'b0;
                dp_next       = '0;
                if (op_reg == OP_ACCESS)
                begin
                    if (in_range && (pm_q != '0))
                    begin
                        res_status_next     = STAT_HIT;
                        res_slot_next       = SLOT_W'(hit_idx);
                        tick_next           = tick_reg + STAMP_W'(1);
                        stamp_next[hit_idx] = tick_next;
                    end
                    else
                    begin
                        res_status_next = STAT_FAILED;
                    end
                end
            end
            ST_SEARCH:
            begin
                pick_next = sr_idx;
                if (sr_done)
                begin
                    ow_re = 1'b1;
                    if ((op_reg == OP_EVICT) && !sr_found)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                end
            end
            ST_OWNER:
            begin
                pm_we    = 1'b1;
                pm_waddr = PAW'(ow_q);
                dv_next  = 1'b1;
                dp_next  = ow_q;
                if (op_reg == OP_EVICT)
                begin
                    used_next[pick_reg] = 1'b0;
                    res_status_next     = STAT_EVICTED;
                    res_slot_next       = SLOT_W'(pick_reg);
                    res_dv_next         = 1'b1;
                    res_dp_next         = ow_q;
                end
            end
            ST_COMMIT:
            begin
                pm_we                = 1'b1;
                pm_waddr             = PAW'(page_reg);
                pm_wdata             = PMW'(pick_reg) + PMW'(1);
                ow_we                = 1'b1;
                used_next[pick_reg]  = 1'b1;
                tick_next            = tick_reg + STAMP_W'(1);
                stamp_next[pick_reg] = tick_next;
                res_status_next      = STAT_LOADED;
                res_slot_next        = SLOT_W'(pick_reg);
                res_dv_next          = dv_reg;
                res_dp_next          = dv_reg ? dp_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            stamp_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            stamp_reg <= stamp_next;
            tick_reg  <= tick_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            page_reg <= s_tdata[PAGE_W-1:0];
            ok_reg   <= s_tdata[PAGE_W];
        end
        pick_reg       <= pick_next;
        dv_reg         <= dv_next;
        dp_reg         <= dp_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_dv_reg     <= res_dv_next;
        res_dp_reg     <= res_dp_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_dv_reg     <= res_dv_reg;
            out_dp_reg     <= res_dp_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_dp_reg, out_dv_reg, out_slot_reg};

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lsc_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [2:0] slot;
        logic       dv;
        logic [9:0] dp;
    } cache_resp_t;

    typedef struct packed {
        logic        is_cfg;
        logic        op;
        logic [9:0]  page;
        logic        ok;
        logic [31:0] cfg;
        logic        typed;
        cache_resp_t resp;
    } dir_row_t;

    localparam int STALL_HOLD = 300;
    localparam int SETTLE_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the cache state
    logic [3:0]  map_of_page [1024];
    logic [9:0]  owner_of_slot [8];
    logic        slot_busy [8];
    logic [63:0] slot_tick [8];
    logic [63:0] tick_count;
    logic [3:0]  active_cfg;

    cache_resp_t pending_results [$];
    dir_row_t    dir_rows [$];

    int   err_count;
    int   items_sent;
    int   cfg_count;
    int   n_hit;
    int   n_loaded;
    int   n_failed;
    int   n_evicted;
    int   n_empty;
    bit   no_idle;
    int   hold_req;

    lru_slot_page_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cache_resp_t mk_resp(status_t st, int slot, logic dv, int dp);
        cache_resp_t r;
        r.status = st;
        r.slot   = slot[2:0];
        r.dv     = dv;
        r.dp     = dp[9:0];
        return r;
    endfunction

    function automatic cache_resp_t predict_cache_op(logic op, logic [9:0] page, logic ok);
        cache_resp_t r;
        int   live;
        int   best;
        bit   found;
        logic [9:0] victim;
        r = mk_resp(STAT_FAILED, 0, 1'b0, 0);
        live = (active_cfg == 4'd0) ? 1 : ((active_cfg > 4'd8) ? 8 : int'(active_cfg));
        best = 0;
        found = 1'b0;
        if (op == OP_EVICT)
        begin
            for (int i = 0; i < live; i++)
            begin
                if (slot_busy[i] && (!found || slot_tick[i] < slot_tick[best]))
                begin
                    best = i;
                    found = 1'b1;
                end
            end
            if (!found)
                return mk_resp(STAT_EMPTY, 0, 1'b0, 0);
            victim = owner_of_slot[best];
            map_of_page[victim] = 4'd0;
            slot_busy[best] = 1'b0;
            return mk_resp(STAT_EVICTED, best, 1'b1, int'(victim));
        end
        if (map_of_page[page] != 4'd0)
        begin
            best = int'(map_of_page[page]) - 1;
            tick_count = tick_count + 64'd1;
            slot_tick[best] = tick_count;
            return mk_resp(STAT_HIT, best, 1'b0, 0);
        end
        if (!ok)
            return r;
        for (int i = 0; i < live; i++)
        begin
            if (!found && !slot_busy[i])
            begin
                best = i;
                found = 1'b1;
            end
        end
        r = mk_resp(STAT_LOADED, 0, 1'b0, 0);
        if (!found)
        begin
            best = 0;
            for (int i = 1; i < live; i++)
            begin
                if (slot_tick[i] < slot_tick[best])
                    best = i;
            end
            victim = owner_of_slot[best];
            map_of_page[victim] = 4'd0;
            r.dv = 1'b1;
            r.dp = victim;
        end
        slot_busy[best] = 1'b1;
        owner_of_slot[best] = page;
        map_of_page[page] = 4'(best + 1);
        tick_count = tick_count + 64'd1;
        slot_tick[best] = tick_count;
        r.slot = best[2:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        if (err_count < 100)
            $display("mismatch at %0t ns: %s", $time, what);
        err_count++;
    endtask

    task automatic send_op(input logic op, input logic [9:0] page, input logic ok,
                           input logic typed, input cache_resp_t typed_resp);
        int gap;
        cache_resp_t pred;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, ok, page};
        do @(posedge clk); while (!s_tready);
        pred = predict_cache_op(op, page, ok);
        pending_results = {pending_results, (typed ? typed_resp : pred)};
        items_sent++;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write then read back; called right after drain_pipeline, on a falling edge
    task automatic write_active_slots(input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ACTIVE_SLOTS, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        active_cfg = value[3:0];
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {28'd0, value[3:0]})
            flag_mismatch($sformatf("active_slots read %0h, wrote %0h", prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_count++;
    endtask

    task automatic add_op(input logic op, input int page, input logic ok,
                          input logic typed, input cache_resp_t resp);
        dir_row_t row;
        row = '{is_cfg: 1'b0, op: op, page: page[9:0], ok: ok, cfg: 32'd0,
                typed: typed, resp: resp};
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_cfg(input logic [31:0] value);
        dir_row_t row;
        row = '{is_cfg: 1'b1, op: OP_ACCESS, page: 10'd0, ok: 1'b0, cfg: value,
                typed: 1'b0, resp: '0};
        dir_rows = {dir_rows, row};
    endtask

    task automatic run_phase(input int count, input logic [3:0] active, input bit calm,
                             input bit squeeze);
        int   base;
        int   pr;
        logic op;
        logic ok;
        logic [9:0] page;
        drain_pipeline();
        write_active_slots({28'($urandom_range(0, 32'h0fff_ffff)), active});
        no_idle = calm;
        if (squeeze)
            hold_req++;
        base = $urandom_range(0, 1023);
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(0, 99) < 12) ? OP_EVICT : OP_ACCESS;
            pr = $urandom_range(0, 99);
            if (pr < 62)
                page = 10'((base + $urandom_range(0, 10)) % 1024);
            else if (pr < 70)
                page = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            else
                page = 10'($urandom_range(0, 1023));
            ok = ($urandom_range(0, 99) < 85);
            send_op(op, page, ok, 1'b0, '0);
        end
        no_idle = 1'b0;
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin : result_side
        int stall_left;
        int g;
        int hold_seen;
        stall_left = 0;
        hold_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                stall_left = STALL_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    stall_left = g - 1;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cache_resp_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result transaction with nothing pending");
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser !== e.status)
                    flag_mismatch($sformatf("status %0d, want %0d", m_tuser, e.status));
                if (m_tdata[2:0] !== e.slot)
                    flag_mismatch($sformatf("slot %0d, want %0d", m_tdata[2:0], e.slot));
                if (m_tdata[3] !== e.dv)
                    flag_mismatch($sformatf("displaced_valid %0b, want %0b", m_tdata[3], e.dv));
                if (m_tdata[13:4] !== e.dp)
                    flag_mismatch($sformatf("displaced_page %0d, want %0d",
                                            m_tdata[13:4], e.dp));
                case (e.status)
                    STAT_HIT:     n_hit++;
                    STAT_LOADED:  n_loaded++;
                    STAT_FAILED:  n_failed++;
                    STAT_EVICTED: n_evicted++;
                    default:      n_empty++;
                endcase
            end
        end
    end

    initial
    begin
        logic [3:0] phase_cfg [12];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'd0;
        s_tuser  = OP_ACCESS;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        err_count = 0;
        items_sent = 0;
        cfg_count = 0;
        n_hit = 0;
        n_loaded = 0;
        n_failed = 0;
        n_evicted = 0;
        n_empty = 0;
        no_idle = 1'b0;
        hold_req = 0;
        for (int i = 0; i < 1024; i++)
            map_of_page[i] = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            owner_of_slot[i] = 10'd0;
            slot_busy[i] = 1'b0;
            slot_tick[i] = 64'd0;
        end
        tick_count = 64'd0;
        active_cfg = 4'd8;
        phase_cfg = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8};

        add_op(OP_ACCESS, 0, 1'b0, 1'b1, mk_resp(STAT_FAILED, 0, 1'b0, 0));
        add_op(OP_EVICT, 1023, 1'b1, 1'b1, mk_resp(STAT_EMPTY, 0, 1'b0, 0));
        add_op(OP_ACCESS, 0, 1'b1, 1'b1, mk_resp(STAT_LOADED, 0, 1'b0, 0));
        add_op(OP_ACCESS, 1023, 1'b1, 1'b1, mk_resp(STAT_LOADED, 1, 1'b0, 0));
        add_op(OP_ACCESS, 0, 1'b0, 1'b1, mk_resp(STAT_HIT, 0, 1'b0, 0));
        add_op(OP_EVICT, 0, 1'b0, 1'b1, mk_resp(STAT_EVICTED, 1, 1'b1, 1023));
        add_op(OP_ACCESS, 1023, 1'b0, 1'b1, mk_resp(STAT_FAILED, 0, 1'b0, 0));
        add_op(OP_ACCESS, 512, 1'b1, 1'b0, '0);
        add_op(OP_ACCESS, 341, 1'b1, 1'b0, '0);
        add_op(OP_ACCESS, 682, 1'b1, 1'b0, '0);
        // shrink the pool: page in slot 3 still hits
        add_cfg(32'd2);
        add_op(OP_ACCESS, 682, 1'b0, 1'b0, '0);
        add_op(OP_ACCESS, 85, 1'b1, 1'b0, '0);
        add_op(OP_ACCESS, 938, 1'b1, 1'b0, '0);
        // zero acts as one slot
        add_cfg(32'hffff_fff0);
        add_op(OP_ACCESS, 1000, 1'b1, 1'b0, '0);
        add_op(OP_EVICT, 1000, 1'b0, 1'b0, '0);
        add_op(OP_EVICT, 0, 1'b1, 1'b0, '0);
        add_op(OP_ACCESS, 341, 1'b0, 1'b0, '0);
        // above the slot count acts as the full pool
        add_cfg(32'd15);
        add_op(OP_ACCESS, 700, 1'b1, 1'b0, '0);
        add_op(OP_ACCESS, 1, 1'b1, 1'b0, '0);
        add_op(OP_EVICT, 0, 1'b0, 1'b0, '0);
        add_op(OP_EVICT, 0, 1'b0, 1'b0, '0);
        add_op(OP_EVICT, 0, 1'b0, 1'b0, '0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain_pipeline();
                write_active_slots(dir_rows[i].cfg);
            end
            else
                send_op(dir_rows[i].op, dir_rows[i].page, dir_rows[i].ok,
                        dir_rows[i].typed, dir_rows[i].resp);
        end

        for (int p = 0; p < 12; p++)
            run_phase(128, phase_cfg[p], (p == 5), (p == 2 || p == 8));

        drain_pipeline();
        $display("ran %0d op transactions across %0d active_slots settings",
                 items_sent, cfg_count);
        $display("hits %0d, loads %0d, failed loads %0d, evictions %0d, empty evicts %0d",
                 n_hit, n_loaded, n_failed, n_evicted, n_empty);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== lru_slot_page_cache.f =====
design/lsc_pkg.sv
design/lsc_ram.sv
design/lsc_lru_search.sv
design/lru_slot_page_cache.sv
sim/tb_top.sv
